### rtl/sgps_pkg.sv
package sgps_pkg;

  // device and page geometry
  localparam int ADDR_BITS  = 40;
  localparam int PAGE_BITS  = 12;

  // field widths
  localparam int SEG_ADDR_W = 64;
  localparam int SEG_LEN_W  = 18;
  localparam int PA_W       = 40;
  localparam int IDX_W      = 16;
  localparam int KIND_W     = 3;

  // per-segment page budget
  localparam int MAX_SPAN   = 63;
  localparam int SPAN_W     = 6;
  localparam int SUM_W      = 20;

  // front-to-back queue
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [SEG_ADDR_W-1:0] ADDR_HI_MASK =
    ~((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [PA_W-1:0] PAGE_SIZE = PA_W'(64'd1 << PAGE_BITS);
  localparam logic [PA_W-1:0] PAGE_MASK = PAGE_SIZE - PA_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_PAGE     = 3'd0,
    KIND_OK       = 3'd1,
    KIND_BAD      = 3'd2,
    KIND_OVERFLOW = 3'd3,
    KIND_MISMATCH = 3'd4
  } kind_t;

  // classified segment, front to back
  typedef struct packed {
    logic [PA_W-1:0]   addr;     // start address, low bits
    logic [PA_W-1:0]   next_pg;  // first page boundary after start
    logic [SPAN_W-1:0] span;     // pages touched
    logic              bad;
    logic              last;
  } seg_cmd_t;

endpackage

### rtl/sgps_ifs.sv
interface sgps_in_if;
  logic                             valid;
  logic                             ready;
  logic [sgps_pkg::SEG_ADDR_W-1:0]  seg_addr;
  logic [sgps_pkg::SEG_LEN_W-1:0]   seg_len;
  logic                             seg_last;

  modport source (output valid, seg_addr, seg_len, seg_last, input ready);
  modport sink   (input valid, seg_addr, seg_len, seg_last, output ready);
endinterface

interface sgps_out_if;
  logic                         valid;
  logic                         ready;
  logic [sgps_pkg::KIND_W-1:0]  kind;
  logic [sgps_pkg::PA_W-1:0]    page_addr;
  logic [sgps_pkg::IDX_W-1:0]   page_index;
  logic                         run_end;

  modport source (output valid, kind, page_addr, page_index, run_end, input ready);
  modport sink   (input valid, kind, page_addr, page_index, run_end, output ready);
endinterface

interface sgps_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sgps_pkg::IDX_W-1:0]   expected_pages;

  modport source (output valid, expected_pages, input ready);
  modport sink   (input valid, expected_pages, output ready);
endinterface

### rtl/sg_segment_page_splitter.sv
// Scatter-gather segment to page list splitter.
// in_if  : one item per segment (seg_addr, seg_len, seg_last), valid/ready.
// out_if : page entries and list status items (kind, page_addr, page_index,
//          run_end); run_end flags the last item a segment produces.
// cfg_if : write of expected_pages, always ready; write only while idle.
// A front stage registers and classifies each segment (bad checks, page
// span, first boundary), a two-entry queue decouples it from the back
// sequencer, which emits one item per cycle from its output register
// while it runs a segment and out_if.ready stays high. A segment's first
// item passes the front register, the queue and the back sequencer's run
// state on its way out. The back sequencer pops a segment, then emits all
// its items before its next pop; segments dropped after an error emit none.
// Reset (rst_n low, synchronous) empties front and queue, clears the page
// count, the abort flag and expected_pages.
// When out_if.ready is low the output register holds its item, the back
// stalls, then the queue fills and in_if.ready drops.
module sg_segment_page_splitter (
  input  logic        clk,
  input  logic        rst_n,
  sgps_in_if.sink     in_if,
  sgps_out_if.source  out_if,
  sgps_cfg_if.sink    cfg_if
);

  logic [sgps_pkg::IDX_W-1:0] exp_r;
  logic                       push;
  sgps_pkg::seg_cmd_t         push_cmd;
  logic                       q_ready;
  logic                       q_valid;
  sgps_pkg::seg_cmd_t         q_cmd;
  logic                       pop;

  // config register: no side effect on list state
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= '0;
    end else if (cfg_if.valid) begin
      exp_r <= cfg_if.expected_pages;
    end
  end

  sgps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready)
  );

  sgps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  sgps_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .pop            (pop),
    .expected_pages (exp_r),
    .out_if         (out_if)
  );

  // back only pops a queue that holds an entry
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

  // status items never carry an address
  a_status_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.kind != sgps_pkg::KIND_PAGE) |-> out_if.page_addr == '0)
    else $error("status item with address");

  // every status item closes the run of its segment
  a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.kind != sgps_pkg::KIND_PAGE) |-> out_if.run_end)
    else $error("status item without run_end");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("output valid after reset");

endmodule

### rtl/sgps_front.sv
module sgps_front (
  input  logic                clk,
  input  logic                rst_n,
  sgps_in_if.sink             in_if,
  output logic                push,
  output sgps_pkg::seg_cmd_t  push_cmd,
  input  logic                q_ready
);

  logic                              valid_r;
  sgps_pkg::seg_cmd_t                cmd_r;
  sgps_pkg::seg_cmd_t                cmd_nxt;
  logic [sgps_pkg::SUM_W-1:0]        sum;
  logic [sgps_pkg::SUM_W-1:0]        span_full;
  logic [sgps_pkg::PA_W-1:0]         addr_lo;
  logic                              accept;

  assign in_if.ready = !valid_r || q_ready;
  assign accept      = in_if.valid && in_if.ready;
  assign push        = valid_r && q_ready;
  assign push_cmd    = cmd_r;

  always_comb begin
    addr_lo   = in_if.seg_addr[sgps_pkg::PA_W-1:0];
    sum       = sgps_pkg::SUM_W'(in_if.seg_addr[sgps_pkg::PAGE_BITS-1:0])
              + sgps_pkg::SUM_W'(in_if.seg_len)
              + sgps_pkg::SUM_W'(sgps_pkg::PAGE_MASK);
    span_full = sum >> sgps_pkg::PAGE_BITS;

    cmd_nxt.addr    = addr_lo;
    cmd_nxt.next_pg = (addr_lo & ~sgps_pkg::PAGE_MASK) + sgps_pkg::PAGE_SIZE;
    cmd_nxt.span    = sgps_pkg::SPAN_W'(span_full);
    cmd_nxt.last    = in_if.seg_last;
    cmd_nxt.bad     = (in_if.seg_len == '0) || (in_if.seg_addr == '0)
                   || ((in_if.seg_addr & sgps_pkg::ADDR_HI_MASK) != '0)
                   || (span_full > sgps_pkg::SUM_W'(sgps_pkg::MAX_SPAN));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (q_ready) begin
      valid_r <= 1'b0;
    end
  end

endmodule

### rtl/sgps_queue.sv
module sgps_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sgps_pkg::seg_cmd_t  push_cmd,
  output logic                q_ready,
  output logic                q_valid,
  output sgps_pkg::seg_cmd_t  q_cmd,
  input  logic                pop
);

  sgps_pkg::seg_cmd_t            mem_r [sgps_pkg::QDEPTH];
  logic [sgps_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [sgps_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [sgps_pkg::QPTR_W:0]     count_r;

  assign q_ready = (count_r != (sgps_pkg::QPTR_W+1)'(sgps_pkg::QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == sgps_pkg::QPTR_W'(sgps_pkg::QDEPTH - 1))
                  ? '0 : wr_ptr_r + sgps_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == sgps_pkg::QPTR_W'(sgps_pkg::QDEPTH - 1))
                  ? '0 : rd_ptr_r + sgps_pkg::QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + (sgps_pkg::QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (sgps_pkg::QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/sgps_back.sv
module sgps_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  sgps_pkg::seg_cmd_t           q_cmd,
  output logic                         pop,
  input  logic [sgps_pkg::IDX_W-1:0]   expected_pages,
  sgps_out_if.source                   out_if
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                          state_r, state_nxt;
  sgps_pkg::seg_cmd_t              cur_r, cur_nxt;
  logic [sgps_pkg::SPAN_W-1:0]     k_r, k_nxt;
  logic [sgps_pkg::PA_W-1:0]       pg_r, pg_nxt;
  logic [sgps_pkg::IDX_W-1:0]      wi_r, wi_nxt;
  logic                            aborted_r, aborted_nxt;
  logic                            out_valid_r, out_valid_nxt;
  sgps_pkg::kind_t                 out_kind_r, out_kind_nxt;
  logic [sgps_pkg::PA_W-1:0]       out_addr_r, out_addr_nxt;
  logic [sgps_pkg::IDX_W-1:0]      out_index_r, out_index_nxt;
  logic                            out_end_r, out_end_nxt;
  logic                            can_emit;

  assign out_if.valid      = out_valid_r;
  assign out_if.kind       = out_kind_r;
  assign out_if.page_addr  = out_addr_r;
  assign out_if.page_index = out_index_r;
  assign out_if.run_end    = out_end_r;

  assign can_emit = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    k_nxt         = k_r;
    pg_nxt        = pg_r;
    wi_nxt        = wi_r;
    aborted_nxt   = aborted_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_kind_nxt  = out_kind_r;
    out_addr_nxt  = out_addr_r;
    out_index_nxt = out_index_r;
    out_end_nxt   = out_end_r;
    pop           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (aborted_r) begin
            // dropped segment; the last one closes the list silently
            if (q_cmd.last) begin
              wi_nxt      = '0;
              aborted_nxt = 1'b0;
            end
          end else begin
            cur_nxt   = q_cmd;
            k_nxt     = '0;
            pg_nxt    = q_cmd.next_pg;
            state_nxt = ST_RUN;
          end
        end
      end

      ST_RUN: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = '0;
          out_index_nxt = wi_r;
          out_end_nxt   = 1'b0;
          if (cur_r.bad || (k_r < cur_r.span && wi_r >= expected_pages)) begin
            if (cur_r.bad) begin
              out_kind_nxt = sgps_pkg::KIND_BAD;
            end else begin
              out_kind_nxt = sgps_pkg::KIND_OVERFLOW;
            end
            out_end_nxt  = 1'b1;
            state_nxt    = ST_IDLE;
            if (cur_r.last) begin
              wi_nxt      = '0;
              aborted_nxt = 1'b0;
            end else begin
              aborted_nxt = 1'b1;
            end
          end else if (k_r < cur_r.span) begin
            out_kind_nxt = sgps_pkg::KIND_PAGE;
            out_addr_nxt = (k_r == '0) ? cur_r.addr : pg_r;
            if (k_r != '0) begin
              pg_nxt = pg_r + sgps_pkg::PAGE_SIZE;
            end
            wi_nxt = wi_r + sgps_pkg::IDX_W'(1);
            k_nxt  = k_r + sgps_pkg::SPAN_W'(1);
            if ((k_r + sgps_pkg::SPAN_W'(1)) == cur_r.span && !cur_r.last) begin
              out_end_nxt = 1'b1;
              state_nxt   = ST_IDLE;
            end
          end else begin
            // all pages out on the last segment: report the final count
            if (wi_r == expected_pages) begin
              out_kind_nxt = sgps_pkg::KIND_OK;
            end else begin
              out_kind_nxt = sgps_pkg::KIND_MISMATCH;
            end
            out_end_nxt  = 1'b1;
            wi_nxt       = '0;
            aborted_nxt  = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    k_r         <= k_nxt;
    pg_r        <= pg_nxt;
    out_kind_r  <= out_kind_nxt;
    out_addr_r  <= out_addr_nxt;
    out_index_r <= out_index_nxt;
    out_end_r   <= out_end_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wi_r        <= '0;
      aborted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wi_r        <= wi_nxt;
      aborted_r   <= aborted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
